// ----- src/port_class_hash_table_defines.svh -----
// Assertion macros for the port class hash table
`ifndef PORT_CLASS_HASH_TABLE_DEFINES_SVH
`define PORT_CLASS_HASH_TABLE_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle
`define PCHT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle
`define PCHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/pcht_pkg.sv -----
`default_nettype none
package pcht_pkg;
  localparam int NumBucketsDefault = 256;
  localparam int WaysDefault = 4;
  localparam logic [7:0] MissClass = 8'd255;
  localparam int HashShift = 5;
  localparam logic [8:0] ModulusReset = 9'd251;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_MODULUS = 1'b0,
    REG_DISABLE = 1'b1
  } reg_idx_t;

  // Classified beat handed from front to back
  typedef struct packed {
    logic       operation;
    logic [7:0] proto;
    logic [15:0] port_number;
    logic [7:0] class_value;
    logic [15:0] bucket;
  } work_t;
endpackage
`default_nettype wire

// ----- src/pcht_if.sv -----
`default_nettype none
interface pcht_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  proto;
  logic [15:0] port_number;
  logic [7:0]  class_value;
  modport source (output valid, operation, proto, port_number, class_value, input ready);
  modport sink (input valid, operation, proto, port_number, class_value, output ready);
endinterface

interface pcht_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] found_class;
  logic       hit;
  logic       overflow;
  modport source (output valid, found_class, hit, overflow, input ready);
  modport sink (input valid, found_class, hit, overflow, output ready);
endinterface
`default_nettype wire

// ----- src/pcht_front.sv -----
`default_nettype none
module pcht_front #(
  parameter int NUM_BUCKETS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [8:0]    modulus,
  pcht_in_if.sink            in_ch,
  output pcht_pkg::work_t    wk,
  output logic               wk_valid,
  input  wire logic          wk_ready
);
  import pcht_pkg::*;

  localparam int KW = 17;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } st_t;

  st_t         state;
  logic [KW-1:0] rem;
  logic [KW-1:0] key;
  logic [8:0]  m_eff;
  logic [4:0]  cnt;
  logic [KW:0] trial;
  logic [KW-1:0] rem_next;
  logic        op_q;
  logic [7:0]  proto_q;
  logic [15:0] port_q;
  logic [7:0]  cls_q;

  always_comb begin
    m_eff = modulus;
    if (modulus == 9'd0) m_eff = 9'd1;
    if (32'(modulus) > NUM_BUCKETS) m_eff = 9'(NUM_BUCKETS > 256 ? 256 : NUM_BUCKETS);
    trial = {rem, key[KW-1]};
    rem_next = (trial >= (KW+1)'(m_eff)) ? KW'(trial - (KW+1)'(m_eff)) : KW'(trial);
  end

  assign in_ch.ready = (state == S_IDLE);
  assign wk_valid = (state == S_DONE);
  assign wk = '{operation: op_q, proto: proto_q, port_number: port_q,
                class_value: cls_q, bucket: 16'(rem)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_ch.valid) begin
          state <= S_DIV;
          cnt <= 5'(KW);
        end
        S_DIV: begin
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) state <= S_DONE;
        end
        S_DONE: if (wk_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      op_q <= in_ch.operation;
      proto_q <= in_ch.proto;
      port_q <= in_ch.port_number;
      cls_q <= in_ch.class_value;
      key <= KW'({9'd0, in_ch.proto} + ({9'd0, in_ch.proto} << HashShift)
                 + {1'b0, in_ch.port_number});
      rem <= '0;
    end else if (state == S_DIV) begin
      rem <= rem_next;
      key <= {key[KW-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

// ----- src/pcht_fifo.sv -----
`default_nettype none
module pcht_fifo (
  input  wire logic       clk,
  input  wire logic       rst,
  input  pcht_pkg::work_t wdata,
  input  wire logic       wvalid,
  output logic            wready,
  output pcht_pkg::work_t rdata,
  output logic            rvalid,
  input  wire logic       rready
);
  import pcht_pkg::*;

  work_t mem [2];
  logic  wp, rp;
  logic [1:0] count;

  assign wready = (count != 2'd2);
  assign rvalid = (count != 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (wvalid && wready) wp <= ~wp;
      if (rvalid && rready) rp <= ~rp;
      count <= count + 2'(wvalid && wready) - 2'(rvalid && rready);
    end
  end

  always_ff @(posedge clk) begin
    if (wvalid && wready) mem[wp] <= wdata;
  end
endmodule
`default_nettype wire

// ----- src/pcht_back.sv -----
`default_nettype none
module pcht_back #(
  parameter int NUM_BUCKETS = 256,
  parameter int WAYS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       lookup_disabled,
  input  pcht_pkg::work_t wk,
  input  wire logic       wk_valid,
  output logic            wk_ready,
  pcht_out_if.source      out_ch
);
  import pcht_pkg::*;

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SW = BW + WW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FILL  = 6'b000010,
    S_SREAD = 6'b000100,
    S_CMP   = 6'b001000,
    S_OUT   = 6'b010000,
    S_CLR   = 6'b100000
  } st_t;

  st_t          state;
  logic [2:0]   fill_mem [NUM_BUCKETS];
  logic [31:0]  slot_mem [NUM_BUCKETS * (1 << WW)];
  logic [2:0]   fill_q;
  logic [31:0]  slot_q;
  logic [BW-1:0] bkt;
  logic [BW:0]  clr_idx;
  logic [2:0]   way;
  work_t        cur;
  logic [SW-1:0] rd_addr;
  logic [7:0]   res_class;
  logic         res_hit;
  logic         res_ovf;

  assign bkt = BW'(cur.bucket);
  assign rd_addr = SW'({bkt, {WW{1'b0}}}) + SW'(way[WW-1:0]);
  assign wk_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (BW+1)'(NUM_BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (wk_valid) state <= S_FILL;
        S_FILL: begin
          way <= '0;
          if (cur.operation == OP_INSERT || lookup_disabled) state <= S_OUT;
          else state <= S_SREAD;
        end
        S_SREAD: begin
          if (way >= fill_q || way >= 3'(WAYS)) state <= S_OUT;
          else state <= S_CMP;
        end
        S_CMP: begin
          if (slot_q[31:24] == cur.proto && slot_q[23:8] == cur.port_number)
            state <= S_OUT;
          else begin
            way <= way + 3'd1;
            state <= S_SREAD;
          end
        end
        S_OUT: if (!out_ch.valid || out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fill_q <= fill_mem[(state == S_IDLE) ? BW'(wk.bucket) : bkt];
    slot_q <= slot_mem[rd_addr];
    if (state == S_CLR) fill_mem[clr_idx[BW-1:0]] <= 3'd0;
    if (state == S_IDLE && wk_valid) cur <= wk;
    if (state == S_FILL && cur.operation == OP_INSERT && fill_q < 3'(WAYS)) begin
      fill_mem[bkt] <= fill_q + 3'd1;
      slot_mem[SW'({bkt, {WW{1'b0}}}) + SW'(fill_q[WW-1:0])] <=
        {cur.proto, cur.port_number, cur.class_value};
    end
    if (state == S_FILL) begin
      res_class <= MissClass;
      res_hit <= 1'b0;
      res_ovf <= (cur.operation == OP_INSERT) && (fill_q >= 3'(WAYS));
    end
    if (state == S_CMP && slot_q[31:24] == cur.proto && slot_q[23:8] == cur.port_number) begin
      res_class <= slot_q[7:0];
      res_hit <= 1'b1;
    end
    if (state == S_OUT && (!out_ch.valid || out_ch.ready)) begin
      out_ch.found_class <= res_class;
      out_ch.hit <= res_hit;
      out_ch.overflow <= res_ovf;
    end
  end
endmodule
`default_nettype wire

// ----- src/port_class_hash_table.sv -----
// Path from input beat to result: bit-serial modulo of the key in the front, a queue
// hop, then a fill read, and a slot read and compare for each way searched.
// The front can take a new beat while the back still works on earlier ones.
// Reset: synchronous, active high; after reset a clearing pass over all NUM_BUCKETS
// buckets zeroes the fill counts before the back takes its first beat.
`default_nettype none
`include "port_class_hash_table_defines.svh"
module port_class_hash_table #(
  parameter int NUM_BUCKETS = pcht_pkg::NumBucketsDefault,
  parameter int WAYS = pcht_pkg::WaysDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  pcht_in_if.sink          in_ch,
  pcht_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:2]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pcht_pkg::*;

  logic [8:0] modulus;
  logic       lookup_disabled;
  work_t      f_wk, b_wk;
  logic       f_valid, f_ready, b_valid, b_ready;
  logic       pwr;

  assign pready = 1'b1;
  assign pwr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_DISABLE) ? {31'd0, lookup_disabled} : {23'd0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModulusReset;
      lookup_disabled <= 1'b0;
    end else if (pwr) begin
      if (paddr[2] == REG_MODULUS) modulus <= pwdata[8:0];
      else lookup_disabled <= pwdata[0];
    end
  end

  pcht_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk, .rst, .modulus, .in_ch, .wk(f_wk), .wk_valid(f_valid), .wk_ready(f_ready)
  );

  pcht_fifo u_fifo (
    .clk, .rst, .wdata(f_wk), .wvalid(f_valid), .wready(f_ready),
    .rdata(b_wk), .rvalid(b_valid), .rready(b_ready)
  );

  pcht_back #(.NUM_BUCKETS(NUM_BUCKETS), .WAYS(WAYS)) u_back (
    .clk, .rst, .lookup_disabled, .wk(b_wk), .wk_valid(b_valid), .wk_ready(b_ready),
    .out_ch
  );

  `PCHT_ASSERT_IMP(a_bucket_range, f_valid, 32'(f_wk.bucket) < NUM_BUCKETS)
  `PCHT_ASSERT_IMP(a_hit_no_ovf, out_ch.valid, !(out_ch.hit && out_ch.overflow))
  `PCHT_ASSERT_IMP(a_miss_class, out_ch.valid && !out_ch.hit, out_ch.found_class == MissClass)
  `PCHT_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
endmodule
`default_nettype wire

// ----- test/tb_port_class_hash_table.sv -----
`timescale 1ns / 100ps
module tb_port_class_hash_table;
  import pcht_pkg::*;

  localparam int NB = NumBucketsDefault;
  localparam int NW = WaysDefault;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:2] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pcht_in_if in_ch();
  pcht_out_if out_ch();

  port_class_hash_table u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [7:0] found_class;
    logic       hit;
    logic       overflow;
  } verdict_t;

  typedef struct {
    op_t         op;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [7:0]  cls;
    bit          typed;
    verdict_t    want;
  } row_t;

  logic [8:0] modulus_q;
  logic       disabled_q;
  int         fill_q [NB];
  logic [31:0] slot_q [NB*NW];
  verdict_t   verdict_q[$];
  int         fail_cnt = 0;
  bit         rx_stall_en = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.proto = '0;
    in_ch.port_number = '0;
    in_ch.class_value = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int bucket_index(logic [7:0] p, logic [15:0] port);
    int m;
    int k;
    m = modulus_q;
    k = p * 33 + port;
    if (m == 0) m = 1;
    if (m > NB) m = NB;
    return k % m;
  endfunction

  function automatic verdict_t classify(op_t op, logic [7:0] p, logic [15:0] port,
                                        logic [7:0] cls);
    verdict_t v;
    int b;
    int f;
    v = '{found_class: MissClass, hit: 1'b0, overflow: 1'b0};
    b = bucket_index(p, port);
    f = fill_q[b];
    if (op == OP_INSERT) begin
      if (f >= NW) begin
        v.overflow = 1'b1;
      end else begin
        slot_q[b*NW+f] = {p, port, cls};
        fill_q[b] = f + 1;
      end
    end else if (!disabled_q) begin
      for (int i = 0; i < f; i++) begin
        if (slot_q[b*NW+i][31:24] == p && slot_q[b*NW+i][23:8] == port) begin
          v.found_class = slot_q[b*NW+i][7:0];
          v.hit = 1'b1;
          break;
        end
      end
    end
    return v;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= idx;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MODULUS) modulus_q = val[8:0];
    else disabled_q = val[0];
  endtask

  task automatic send_beat(op_t op, logic [7:0] p, logic [15:0] port, logic [7:0] cls,
                           bit typed, verdict_t want);
    verdict_t v;
    v = classify(op, p, port, cls);
    if (typed && v != want)
      $error("table row disagrees: expected %h predicted %h", want, v);
    verdict_q.push_back(v);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.proto <= p;
    in_ch.port_number <= port;
    in_ch.class_value <= cls;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_stall_en || ($urandom_range(0, 3) != 0);
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt++;
        end else begin
          verdict_t w;
          w = verdict_q.pop_front();
          if (out_ch.found_class !== w.found_class) begin
            $error("found_class expected %0d actual %0d", w.found_class, out_ch.found_class);
            fail_cnt++;
          end
          if (out_ch.hit !== w.hit) begin
            $error("hit expected %0d actual %0d", w.hit, out_ch.hit);
            fail_cnt++;
          end
          if (out_ch.overflow !== w.overflow) begin
            $error("overflow expected %0d actual %0d", w.overflow, out_ch.overflow);
            fail_cnt++;
          end
        end
      end
    end
  end

  function automatic row_t mk(op_t op, logic [7:0] p, logic [15:0] port, logic [7:0] cls,
                              bit typed = 0, logic [7:0] fc = MissClass,
                              logic h = 0, logic o = 0);
    row_t r;
    r.op = op; r.proto = p; r.port = port; r.cls = cls; r.typed = typed;
    r.want = '{found_class: fc, hit: h, overflow: o};
    return r;
  endfunction

  task automatic random_phase(int n, int key_span);
    int left;
    int gap;
    op_t op;
    logic [7:0] p;
    logic [15:0] port;
    left = n;
    while (left > 0) begin
      for (int k = $urandom_range(1, 12); k > 0 && left > 0; k--) begin
        op = ($urandom_range(0, 2) == 0) ? OP_INSERT : OP_LOOKUP;
        if ($urandom_range(0, 4) == 0) begin
          p = 8'($urandom);
          port = 16'($urandom);
        end else begin
          p = 8'($urandom_range(0, key_span));
          port = {$urandom_range(0, 1) ? 8'hff : 8'h00, 8'($urandom_range(0, key_span))};
        end
        send_beat(op, p, port, 8'($urandom_range(0, 255)), 0, '0);
        left--;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    row_t rows[$];
    modulus_q = ModulusReset;
    disabled_q = 1'b0;
    foreach (fill_q[i]) fill_q[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(mk(OP_LOOKUP, 8'h00, 16'h0000, 8'h00, 1));
    rows.push_back(mk(OP_INSERT, 8'h00, 16'h0000, 8'h00, 1));
    rows.push_back(mk(OP_LOOKUP, 8'h00, 16'h0000, 8'h00, 1, 8'h00, 1));
    rows.push_back(mk(OP_INSERT, 8'hff, 16'hffff, 8'hfe, 1));
    rows.push_back(mk(OP_LOOKUP, 8'hff, 16'hffff, 8'h00, 1, 8'hfe, 1));
    rows.push_back(mk(OP_INSERT, 8'h01, 16'h0001, 8'hff));
    rows.push_back(mk(OP_LOOKUP, 8'h01, 16'h0001, 8'h00));
    rows.push_back(mk(OP_INSERT, 8'h01, 16'h0001, 8'h07));
    rows.push_back(mk(OP_LOOKUP, 8'h01, 16'h0001, 8'h00));
    for (int i = 0; i < 5; i++)
      rows.push_back(mk(OP_INSERT, 8'h02, 16'(251 * i), 8'(i)));
    rows.push_back(mk(OP_LOOKUP, 8'h02, 16'd753, 8'h00));
    rows.push_back(mk(OP_LOOKUP, 8'h02, 16'd1004, 8'h00));
    rows.push_back(mk(OP_LOOKUP, 8'h55, 16'h5555, 8'haa));
    foreach (rows[i])
      send_beat(rows[i].op, rows[i].proto, rows[i].port, rows[i].cls,
                rows[i].typed, rows[i].want);
    drain();

    reg_write(REG_DISABLE, 32'h1);
    send_beat(OP_LOOKUP, 8'h00, 16'h0000, 8'h00, 1, '{MissClass, 1'b0, 1'b0});
    send_beat(OP_INSERT, 8'h03, 16'h0003, 8'h11, 0, '0);
    drain();
    reg_write(REG_DISABLE, 32'h0);
    reg_write(REG_MODULUS, 32'h0);
    send_beat(OP_INSERT, 8'h09, 16'h0009, 8'h22, 0, '0);
    send_beat(OP_LOOKUP, 8'h09, 16'h0009, 8'h00, 0, '0);
    drain();
    reg_write(REG_MODULUS, 32'h1ff);
    send_beat(OP_INSERT, 8'h80, 16'h8000, 8'h33, 0, '0);
    send_beat(OP_LOOKUP, 8'h80, 16'h8000, 8'h00, 0, '0);
    drain();

    reg_write(REG_MODULUS, 32'd2);
    random_phase(200, 15);
    drain();
    reg_write(REG_MODULUS, 32'd256);
    rx_stall_en = 1'b0;
    random_phase(400, 63);
    drain();
    rx_stall_en = 1'b1;
    reg_write(REG_DISABLE, 32'h1);
    random_phase(150, 31);
    drain();
    reg_write(REG_DISABLE, 32'h0);
    reg_write(REG_MODULUS, 32'd13);
    random_phase(400, 31);
    drain();
    reg_write(REG_MODULUS, 32'd251);
    random_phase(450, 255);
    drain();

    if (fail_cnt == 0) $display("** port_class_hash_table: PASSED **");
    else $display("** port_class_hash_table: FAILED **");
    $finish;
  end

  initial begin
    #20ms;
    $display("** port_class_hash_table: FAILED **");
    $finish;
  end
endmodule

// ----- port_class_hash_table.f -----
+incdir+src
src/pcht_pkg.sv
src/pcht_if.sv
src/pcht_front.sv
src/pcht_fifo.sv
src/pcht_back.sv
src/port_class_hash_table.sv
test/tb_port_class_hash_table.sv
